FILE: rtl/core/ndsaw_pkg.sv
// shared types and constants for the n-dimensional sub-block address walker
// no dependencies; imported by nd_subblock_address_walker and tb
package ndsaw_pkg;

    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_COORD_BITS = 16;

    // fixed field widths of the item and result ports
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 2;
    localparam int SRC_W    = 8;
    localparam int EXT_W    = 16;
    localparam int PT_W     = 16;
    localparam int STRIDE_W = 32;
    localparam int DEST_W   = 50;
    localparam int OCRD_W   = 16;
    localparam int STAT_W   = 3;
    localparam int NUM_OCRD = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RANK_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FILE   = 2'd0,
        OP_LOAD_MATRIX = 2'd1,
        OP_START       = 2'd2,
        OP_STEP        = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_RANK       = 3'd1,
        ST_DIM_INDEX  = 3'd2,
        ST_DUPLICATE  = 3'd3,
        ST_ZERO_LEN   = 3'd4,
        ST_START      = 3'd5,
        ST_UPPER      = 3'd6,
        ST_NOT_ACTIVE = 3'd7
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILE_DIMS   = 2'd0,
        CFG_MATRIX_DIMS = 2'd1,
        CFG_DIM_OFFSET  = 2'd2,
        CFG_PT_OFFSET   = 2'd3
    } t_cfg_idx;

endpackage

FILE: rtl/core/nd_subblock_address_walker.sv
// Sub-block address walker for an N-dimensional data file. Load items fill the file and
// matrix descriptors, a start item validates them and arms the walk, and each step item
// in an armed walk returns the current file coordinates and destination offset and then
// advances the odometer. Every item gives exactly one result. An accepted item is held
// in an input register and its result is then registered in the output register; one
// item is taken every cycle unless the result channel stalls. That rate is set by the
// combinational path from the input register through the descriptor checks, the
// odometer carry chain over MAX_DIMS dimensions and the MAX_DIMS-way sum of the
// per-dimension offset accumulators into the output register. There is no
// multiplier: each dimension keeps position times stride as a running sum.
// Configuration writes end any walk in progress.
// depends on: ndsaw_pkg
module nd_subblock_address_walker
    import ndsaw_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // item channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OP_W-1:0]              i_operation,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic [SRC_W-1:0]             i_source_dim,
    input  logic [EXT_W-1:0]             i_extent,
    input  logic [PT_W-1:0]              i_start_point,
    input  logic signed [STRIDE_W-1:0]   i_stride,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [OCRD_W-1:0]            o_coord_a,
    output logic [OCRD_W-1:0]            o_coord_b,
    output logic [OCRD_W-1:0]            o_coord_c,
    output logic [OCRD_W-1:0]            o_coord_d,
    output logic signed [DEST_W-1:0]     o_dest_offset,
    output logic                         o_last,
    output logic [STAT_W-1:0]            o_status
);

    localparam int CW   = COORD_BITS;
    // compare width: holds a corrected start plus a length without wrapping
    localparam int CMPW = ((CW > PT_W) ? CW : PT_W) + 1;

    // configuration registers
    logic [RANK_W-1:0]  r_file_dims;
    logic [RANK_W-1:0]  r_matrix_dims;
    logic [SRC_W-1:0]   r_dim_off;
    logic [PT_W-1:0]    r_pt_off;

    // descriptor stores
    logic [CW-1:0]              r_fsize  [MAX_DIMS];
    logic [CW-1:0]              r_start  [MAX_DIMS];
    logic [SRC_W-1:0]           r_src    [MAX_DIMS];
    logic [CW-1:0]              r_len    [MAX_DIMS];
    logic signed [STRIDE_W-1:0] r_stride [MAX_DIMS];

    // walk state, kept per file dimension
    logic                       r_active;
    logic                       r_incl   [MAX_DIMS];
    logic [CW-1:0]              r_cur    [MAX_DIMS];
    logic [CW-1:0]              r_base   [MAX_DIMS];
    logic [CW-1:0]              r_pos    [MAX_DIMS];
    logic [CW-1:0]              r_dlen   [MAX_DIMS];
    logic signed [STRIDE_W-1:0] r_dstride[MAX_DIMS];
    logic signed [DEST_W-1:0]   r_acc    [MAX_DIMS];

    // input register
    logic                       r_in_vld;
    logic [OP_W-1:0]            r_in_op;
    logic [SLOT_W-1:0]          r_in_slot;
    logic [SRC_W-1:0]           r_in_src;
    logic [EXT_W-1:0]           r_in_ext;
    logic [PT_W-1:0]            r_in_pt;
    logic signed [STRIDE_W-1:0] r_in_stride;

    // output register
    logic                       r_out_vld;
    logic [OCRD_W-1:0]          r_coord [NUM_OCRD];
    logic signed [DEST_W-1:0]   r_dest;
    logic                       r_last;
    t_status                    r_status;

    logic    in_accept;
    logic    advance;
    t_op     cur_op;

    // start check results
    t_status                    chk_status;
    logic [SRC_W-1:0]           src_c    [MAX_DIMS];
    logic                       map_incl [MAX_DIMS];
    logic [CW-1:0]              map_len  [MAX_DIMS];
    logic signed [STRIDE_W-1:0] map_stride[MAX_DIMS];
    logic [CW-1:0]              cstart   [MAX_DIMS];

    // step results
    logic [CW-1:0]              n_cur  [MAX_DIMS];
    logic [CW-1:0]              n_pos  [MAX_DIMS];
    logic signed [DEST_W-1:0]   n_acc  [MAX_DIMS];
    logic                       step_done;
    logic signed [DEST_W-1:0]   dest_sum;
    logic [OCRD_W-1:0]          coord_v [NUM_OCRD];

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cur_op     = t_op'(r_in_op);

    // descriptor checks and file-to-matrix dimension map
    always_comb begin
        logic              rank_bad;
        logic              found;
        logic              any_zero;
        logic              any_start;
        logic              any_upper;
        logic              idx_bad;
        logic              dup;
        logic [CMPW-1:0]   cs_w;
        logic [CMPW-1:0]   pt_w;
        logic [CMPW-1:0]   upper;

        pt_w      = CMPW'(r_pt_off);
        rank_bad  = (r_file_dims == '0) || (int'(r_file_dims) > MAX_DIMS) ||
                    (r_matrix_dims == '0) || (r_matrix_dims > r_file_dims);
        found     = 1'b0;
        any_zero  = 1'b0;
        any_start = 1'b0;
        any_upper = 1'b0;
        chk_status = ST_OK;

        for (int m = 0; m < MAX_DIMS; m++) begin
            src_c[m] = r_src[m] - r_dim_off;
        end
        for (int f = 0; f < MAX_DIMS; f++) begin
            cstart[f] = CW'(CMPW'(r_start[f]) - pt_w);
        end

        // index then duplicate, dimension by dimension
        for (int i = 0; i < MAX_DIMS; i++) begin
            idx_bad = (r_src[i] < r_dim_off) || (src_c[i] >= SRC_W'(r_file_dims));
            dup     = 1'b0;
            for (int p = 0; p < i; p++) begin
                if (r_src[i] == r_src[p]) begin
                    dup = 1'b1;
                end
            end
            if (!found && (i < int'(r_matrix_dims))) begin
                if (idx_bad) begin
                    chk_status = ST_DIM_INDEX;
                    found      = 1'b1;
                end else if (dup) begin
                    chk_status = ST_DUPLICATE;
                    found      = 1'b1;
                end
            end
        end

        for (int i = 0; i < MAX_DIMS; i++) begin
            if ((i < int'(r_matrix_dims)) && (r_len[i] == '0)) begin
                any_zero = 1'b1;
            end
        end

        for (int f = 0; f < MAX_DIMS; f++) begin
            cs_w = CMPW'(r_start[f]) - pt_w;
            if ((f < int'(r_file_dims)) &&
                ((CMPW'(r_start[f]) < pt_w) || (cs_w >= CMPW'(r_fsize[f])))) begin
                any_start = 1'b1;
            end
        end

        for (int i = 0; i < MAX_DIMS; i++) begin
            for (int f = 0; f < MAX_DIMS; f++) begin
                upper = CMPW'(r_start[f]) - pt_w + CMPW'(r_len[i]) - CMPW'(1);
                if ((i < int'(r_matrix_dims)) && (src_c[i] == SRC_W'(f)) &&
                    (upper >= CMPW'(r_fsize[f]))) begin
                    any_upper = 1'b1;
                end
            end
        end

        priority if (rank_bad) begin
            chk_status = ST_RANK;
        end else if (found) begin
            chk_status = chk_status;
        end else if (any_zero) begin
            chk_status = ST_ZERO_LEN;
        end else if (any_start) begin
            chk_status = ST_START;
        end else if (any_upper) begin
            chk_status = ST_UPPER;
        end else begin
            chk_status = ST_OK;
        end

        // sources are distinct after a good check, so an or-mux picks the one match
        for (int f = 0; f < MAX_DIMS; f++) begin
            map_incl[f]   = 1'b0;
            map_len[f]    = '0;
            map_stride[f] = '0;
            for (int m = 0; m < MAX_DIMS; m++) begin
                if ((m < int'(r_matrix_dims)) && (src_c[m] == SRC_W'(f))) begin
                    map_incl[f]   = 1'b1;
                    map_len[f]    = map_len[f] | r_len[m];
                    map_stride[f] = map_stride[f] | r_stride[m];
                end
            end
        end
    end

    // odometer: lowest included file dimension fastest
    always_comb begin
        logic          carry;
        logic [CW:0]   pos_inc;

        carry = 1'b1;
        for (int f = 0; f < MAX_DIMS; f++) begin
            n_cur[f] = r_cur[f];
            n_pos[f] = r_pos[f];
            n_acc[f] = r_acc[f];
            pos_inc  = (CW+1)'(r_pos[f]) + (CW+1)'(1);
            if (r_incl[f] && carry) begin
                if (pos_inc >= (CW+1)'(r_dlen[f])) begin
                    n_cur[f] = r_base[f];
                    n_pos[f] = '0;
                    n_acc[f] = '0;
                end else begin
                    n_cur[f] = r_cur[f] + CW'(1);
                    n_pos[f] = CW'(pos_inc);
                    n_acc[f] = r_acc[f] + DEST_W'(r_dstride[f]);
                    carry    = 1'b0;
                end
            end
        end
        step_done = carry;
    end

    always_comb begin
        dest_sum = '0;
        for (int f = 0; f < MAX_DIMS; f++) begin
            dest_sum = dest_sum + r_acc[f];
        end
        for (int k = 0; k < NUM_OCRD; k++) begin
            coord_v[k] = '0;
        end
        for (int k = 0; (k < NUM_OCRD) && (k < MAX_DIMS); k++) begin
            coord_v[k] = OCRD_W'(r_cur[k]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_active      <= 1'b0;
            r_file_dims   <= RANK_W'(1);
            r_matrix_dims <= RANK_W'(1);
            r_dim_off     <= '0;
            r_pt_off      <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_fsize[d] <= '0;
            end
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_FILE_DIMS:   r_file_dims   <= RANK_W'(i_cfg_data);
                    CFG_MATRIX_DIMS: r_matrix_dims <= RANK_W'(i_cfg_data);
                    CFG_DIM_OFFSET:  r_dim_off     <= SRC_W'(i_cfg_data);
                    CFG_PT_OFFSET:   r_pt_off      <= PT_W'(i_cfg_data);
                    default:         r_pt_off      <= r_pt_off;
                endcase
                r_active <= 1'b0;
            end else if (advance) begin
                unique case (cur_op)
                    OP_LOAD_FILE: begin
                        r_active <= 1'b0;
                        for (int d = 0; d < MAX_DIMS; d++) begin
                            if (int'(r_in_slot) == d) begin
                                r_fsize[d] <= CW'(r_in_ext);
                            end
                        end
                    end
                    OP_LOAD_MATRIX: r_active <= 1'b0;
                    OP_START:       r_active <= (chk_status == ST_OK);
                    OP_STEP: begin
                        if (r_active && step_done) begin
                            r_active <= 1'b0;
                        end
                    end
                    default:        r_active <= r_active;
                endcase
            end
        end
    end

    // payload: input register, descriptor stores, walk state, results
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op     <= i_operation;
            r_in_slot   <= i_slot;
            r_in_src    <= i_source_dim;
            r_in_ext    <= i_extent;
            r_in_pt     <= i_start_point;
            r_in_stride <= i_stride;
        end

        if (advance) begin
            for (int k = 0; k < NUM_OCRD; k++) begin
                r_coord[k] <= '0;
            end
            r_dest   <= '0;
            r_last   <= 1'b0;
            r_status <= ST_OK;

            unique case (cur_op)
                OP_LOAD_FILE: begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        if (int'(r_in_slot) == d) begin
                            r_start[d] <= CW'(r_in_pt);
                        end
                    end
                end
                OP_LOAD_MATRIX: begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        if (int'(r_in_slot) == d) begin
                            r_src[d]    <= r_in_src;
                            r_len[d]    <= CW'(r_in_ext);
                            r_stride[d] <= r_in_stride;
                        end
                    end
                end
                OP_START: begin
                    r_status <= chk_status;
                    if (chk_status == ST_OK) begin
                        for (int f = 0; f < MAX_DIMS; f++) begin
                            r_cur[f]     <= (f < int'(r_file_dims)) ? cstart[f] : '0;
                            r_base[f]    <= cstart[f];
                            r_pos[f]     <= '0;
                            r_acc[f]     <= '0;
                            r_incl[f]    <= map_incl[f];
                            r_dlen[f]    <= map_len[f];
                            r_dstride[f] <= map_stride[f];
                        end
                    end
                end
                OP_STEP: begin
                    if (!r_active) begin
                        r_status <= ST_NOT_ACTIVE;
                    end else begin
                        for (int k = 0; k < NUM_OCRD; k++) begin
                            r_coord[k] <= coord_v[k];
                        end
                        r_dest <= dest_sum;
                        r_last <= step_done;
                        for (int f = 0; f < MAX_DIMS; f++) begin
                            r_cur[f] <= n_cur[f];
                            r_pos[f] <= n_pos[f];
                            r_acc[f] <= n_acc[f];
                        end
                    end
                end
                default: r_status <= ST_OK;
            endcase
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_coord_a     = r_coord[0];
    assign o_coord_b     = r_coord[1];
    assign o_coord_c     = r_coord[2];
    assign o_coord_d     = r_coord[3];
    assign o_dest_offset = r_dest;
    assign o_last        = r_last;
    assign o_status      = r_status;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench for nd_subblock_address_walker: directed and random load, start and step items
// under several register settings, every result checked against an in-bench odometer model
// depends on: ndsaw_pkg, nd_subblock_address_walker
module tb;
    import ndsaw_pkg::*;

    localparam int NDIM         = DEF_MAX_DIMS;
    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_op                 op;
        logic [SLOT_W-1:0]   slot;
        logic [SRC_W-1:0]    src;
        logic [EXT_W-1:0]    ext;
        logic [PT_W-1:0]     pt;
        logic [STRIDE_W-1:0] stride;
    } t_walk_item;

    typedef struct packed {
        logic [NUM_OCRD-1:0][OCRD_W-1:0] crd;
        logic [DEST_W-1:0]               dest;
        logic                            last;
        t_status                         status;
    } t_walk_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_operation = '0;
    logic [SLOT_W-1:0]          i_slot = '0;
    logic [SRC_W-1:0]           i_source_dim = '0;
    logic [EXT_W-1:0]           i_extent = '0;
    logic [PT_W-1:0]            i_start_point = '0;
    logic signed [STRIDE_W-1:0] i_stride = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [OCRD_W-1:0]          o_coord_a, o_coord_b, o_coord_c, o_coord_d;
    logic signed [DEST_W-1:0]   o_dest_offset;
    logic                       o_last;
    logic [STAT_W-1:0]          o_status;

    nd_subblock_address_walker i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model copy of registers and descriptor stores
    logic [RANK_W-1:0]   fd_reg = 3'd1;
    logic [RANK_W-1:0]   md_reg = 3'd1;
    logic [SRC_W-1:0]    doff_reg = '0;
    logic [PT_W-1:0]     poff_reg = '0;
    logic [EXT_W-1:0]    fsize [NDIM] = '{default: '0};
    logic [PT_W-1:0]     fstart [NDIM] = '{default: '0};
    logic [SRC_W-1:0]    msrc [NDIM] = '{default: '0};
    logic [EXT_W-1:0]    mlen [NDIM] = '{default: '0};
    logic signed [31:0]  mstride [NDIM] = '{default: '0};
    logic [15:0]         cur_crd [NDIM] = '{default: '0};
    logic [15:0]         mpos [NDIM] = '{default: '0};
    bit                  armed = 1'b0;

    t_walk_item   pending_items [$];
    t_walk_result due_results [$];
    t_walk_item   cur_item;

    int unsigned n_pushed = 0, n_taken = 0, n_checked = 0, n_mismatch = 0;
    int unsigned n_walks = 0, n_rejected = 0, n_idle_steps = 0, cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;
    bit          quiet = 1'b0;

    function automatic int unsigned file_of(int m);
        logic [SRC_W-1:0] d;
        d = msrc[m] - doff_reg;
        return d;
    endfunction

    function automatic int matrix_of(int f);
        int m;
        for (m = 0; m < md_reg && m < NDIM; m++)
            if (file_of(m) == f) return m;
        return -1;
    endfunction

    function automatic t_status start_check();
        int unsigned i, p, f, upper;
        if (fd_reg < 1 || fd_reg > NDIM || md_reg < 1 || md_reg > fd_reg) return ST_RANK;
        for (i = 0; i < md_reg; i++) begin
            if (msrc[i] < doff_reg || file_of(i) >= fd_reg) return ST_DIM_INDEX;
            for (p = 0; p < i; p++)
                if (msrc[i] == msrc[p]) return ST_DUPLICATE;
        end
        for (i = 0; i < md_reg; i++)
            if (mlen[i] == 0) return ST_ZERO_LEN;
        for (i = 0; i < fd_reg; i++)
            if (fstart[i] < poff_reg || fstart[i] - poff_reg >= fsize[i]) return ST_START;
        for (i = 0; i < md_reg; i++) begin
            f = file_of(i);
            upper = fstart[f] - poff_reg + mlen[i] - 1;
            if (upper >= fsize[f]) return ST_UPPER;
        end
        return ST_OK;
    endfunction

    // result of one item; updates the model state
    function automatic t_walk_result walker_result(input t_walk_item it);
        t_walk_result r;
        longint       acc;
        int           f, m, top;
        bit           done;
        r = '0;
        r.status = ST_OK;
        case (it.op)
            OP_LOAD_FILE: begin
                fsize[it.slot] = it.ext;
                fstart[it.slot] = it.pt;
                armed = 1'b0;
            end
            OP_LOAD_MATRIX: begin
                msrc[it.slot] = it.src;
                mlen[it.slot] = it.ext;
                mstride[it.slot] = it.stride;
                armed = 1'b0;
            end
            OP_START: begin
                r.status = start_check();
                armed = (r.status == ST_OK);
                if (armed) begin
                    for (f = 0; f < NDIM; f++) begin
                        cur_crd[f] = (f < fd_reg) ? fstart[f] - poff_reg : 16'd0;
                        mpos[f] = '0;
                    end
                end
            end
            default: begin
                if (!armed) begin
                    r.status = ST_NOT_ACTIVE;
                end else begin
                    acc = 0;
                    for (f = 0; f < NDIM; f++) r.crd[f] = cur_crd[f];
                    for (m = 0; m < md_reg && m < NDIM; m++)
                        acc += longint'(mpos[m]) * longint'(mstride[m]);
                    r.dest = acc[DEST_W-1:0];
                    top = 0;
                    for (f = 0; f < fd_reg && f < NDIM; f++)
                        if (matrix_of(f) >= 0) top = f;
                    // odometer, lowest included file dimension fastest
                    done = 1'b0;
                    for (f = 0; f < fd_reg && f < NDIM; f++) begin
                        m = matrix_of(f);
                        if (m >= 0) begin
                            cur_crd[f] = cur_crd[f] + 16'd1;
                            mpos[m] = mpos[m] + 16'd1;
                            if (mpos[m] >= mlen[m]) begin
                                cur_crd[f] = fstart[f] - poff_reg;
                                mpos[m] = '0;
                                if (f == top) begin
                                    done = 1'b1;
                                    break;
                                end
                            end else begin
                                break;
                            end
                        end
                    end
                    if (done) begin
                        armed = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     n_checked, what, want_v, got_v);
    endtask

    task automatic queue_item(input t_op op, input int unsigned slot, input int unsigned src,
                              input int unsigned ext, input int unsigned pt,
                              input logic [31:0] stride);
        t_walk_item it;
        it.op = op;
        it.slot = slot[SLOT_W-1:0];
        it.src = src[SRC_W-1:0];
        it.ext = ext[EXT_W-1:0];
        it.pt = pt[PT_W-1:0];
        it.stride = stride;
        pending_items.push_back(it);
        n_pushed++;
    endtask

    // a well-formed walk with random content, now and then with one descriptor broken
    task automatic queue_walk();
        int unsigned fdv, mdv, hi, f, m, t, pts, steps, lm, fault;
        int unsigned sz [NDIM], cs [NDIM], spt [NDIM], len [NDIM], perm [NDIM];
        logic [SRC_W-1:0] src [NDIM];
        bit mfirst;
        fdv = (fd_reg < 1) ? 1 : (fd_reg > NDIM) ? NDIM : fd_reg;
        mdv = (md_reg < 1) ? 1 : (md_reg > fdv) ? fdv : md_reg;
        for (f = 0; f < NDIM; f++) begin
            sz[f] = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(24, 1);
            hi = (sz[f] - 1 < 65535 - poff_reg) ? sz[f] - 1 : 65535 - poff_reg;
            cs[f] = $urandom_range(hi);
            spt[f] = poff_reg + cs[f];
            perm[f] = f;
        end
        for (f = fdv - 1; f >= 1; f--) begin
            t = $urandom_range(f);
            hi = perm[f];
            perm[f] = perm[t];
            perm[t] = hi;
        end
        // at most one long dimension keeps the point count small
        lm = ($urandom_range(7) == 0) ? $urandom_range(mdv - 1) : NDIM;
        pts = 1;
        for (m = 0; m < NDIM; m++) begin
            hi = sz[perm[m]] - cs[perm[m]];
            if (hi > ((m == lm) ? 12 : 3)) hi = (m == lm) ? 12 : 3;
            len[m] = $urandom_range(hi, 1);
            src[m] = doff_reg + perm[m];
            if (m < mdv) pts = pts * len[m];
        end
        fault = ($urandom_range(99) < 14) ? $urandom_range(4) + 1 : 0;
        if (fault == 3 && mdv < 2) fault = 2;
        case (fault)
            1: len[$urandom_range(mdv - 1)] = 0;
            2: begin
                m = $urandom_range(mdv - 1);
                if (doff_reg > 0 && (doff_reg + fdv > 255 || $urandom_range(1)))
                    src[m] = $urandom_range(doff_reg - 1);
                else
                    src[m] = $urandom_range(255, doff_reg + fdv);
            end
            3: begin
                m = $urandom_range(mdv - 1, 1);
                src[m] = src[$urandom_range(m - 1)];
            end
            4: begin
                f = $urandom_range(fdv - 1);
                if (poff_reg > 0 && $urandom_range(1)) spt[f] = $urandom_range(poff_reg - 1);
                else sz[f] = cs[f];
            end
            5: begin
                m = $urandom_range(mdv - 1);
                len[m] = sz[perm[m]] - cs[perm[m]] + 1;
            end
            default: ;
        endcase
        mfirst = $urandom_range(1);
        for (t = 0; t < 2; t++) begin
            if ((t == 0) == mfirst) begin
                for (m = 0; m < mdv; m++)
                    queue_item(OP_LOAD_MATRIX, m, src[m], len[m], $urandom(), $urandom());
            end else begin
                for (f = 0; f < fdv; f++)
                    queue_item(OP_LOAD_FILE, f, $urandom(), sz[f], spt[f], $urandom());
            end
        end
        queue_item(OP_START, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        if (fault != 0) steps = $urandom_range(2);
        else if ($urandom_range(9) == 0) steps = $urandom_range(pts - 1);
        else steps = pts + (($urandom_range(3) == 0) ? 1 : 0);
        for (t = 0; t < steps; t++)
            queue_item(OP_STEP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic write_config(input int unsigned fd, input int unsigned md,
                                input int unsigned doff, input int unsigned poff);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_FILE_DIMS;
        i_cfg_data <= fd[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_MATRIX_DIMS;
        i_cfg_data <= md[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_DIM_OFFSET;
        i_cfg_data <= doff[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_PT_OFFSET;
        i_cfg_data <= poff[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fd_reg = fd[RANK_W-1:0];
        md_reg = md[RANK_W-1:0];
        doff_reg = doff[SRC_W-1:0];
        poff_reg = poff[PT_W-1:0];
        armed = 1'b0;
    endtask

    task automatic drain();
        while (n_taken != n_pushed || due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned fd, input int unsigned md,
                             input int unsigned doff, input int unsigned poff,
                             input int unsigned target, input bit calm, input bit hold);
        int unsigned first, k;
        write_config(fd, md, doff, poff);
        quiet = calm;
        // a walk left armed by the last phase must be gone after the writes
        queue_item(OP_STEP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        first = n_pushed;
        while (n_pushed - first < target) begin
            if ($urandom_range(99) < 8) begin
                for (k = $urandom_range(3, 1); k > 0; k--)
                    queue_item(t_op'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom());
            end else begin
                queue_walk();
            end
        end
        if (hold) hold_req = 1'b1;
        drain();
        quiet = 1'b0;
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            due_results.push_back(walker_result(cur_item));
            n_taken++;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                cur_item = pending_items.pop_front();
                i_operation <= cur_item.op;
                i_slot <= cur_item.slot;
                i_source_dim <= cur_item.src;
                i_extent <= cur_item.ext;
                i_start_point <= cur_item.pt;
                i_stride <= cur_item.stride;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin : result_monitor
        t_walk_result want, seen;
        int k;
        if (o_out_valid && !i_out_stall) begin
            seen.crd[0] = o_coord_a;
            seen.crd[1] = o_coord_b;
            seen.crd[2] = o_coord_c;
            seen.crd[3] = o_coord_d;
            seen.dest = o_dest_offset;
            seen.last = o_last;
            seen.status = t_status'(o_status);
            if (due_results.size() == 0) begin
                flag_mismatch("result with nothing expected, status", 0, seen.status);
            end else begin
                want = due_results.pop_front();
                n_checked++;
                for (k = 0; k < NUM_OCRD; k++)
                    if (seen.crd[k] !== want.crd[k])
                        flag_mismatch($sformatf("coord %0d", k), want.crd[k], seen.crd[k]);
                if (seen.dest !== want.dest) flag_mismatch("dest_offset", want.dest, seen.dest);
                if (seen.last !== want.last) flag_mismatch("last", want.last, seen.last);
                if (seen.status !== want.status)
                    flag_mismatch("status", want.status, seen.status);
                if (want.last) n_walks++;
                if (want.status == ST_NOT_ACTIVE) n_idle_steps++;
                else if (want.status != ST_OK) n_rejected++;
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_results.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_config(3, 2, 0, 0);
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_FILE, 0, 0, 5, 0, 0);
        queue_item(OP_LOAD_FILE, 1, 0, 65535, 65534, 0);
        queue_item(OP_LOAD_FILE, 2, 0, 0, 0, 0);
        queue_item(OP_LOAD_FILE, 3, 255, 1, 0, 32'hffff_ffff);
        queue_item(OP_LOAD_MATRIX, 0, 0, 2, 65535, 32'h7fff_ffff);
        queue_item(OP_LOAD_MATRIX, 1, 1, 2, 0, 32'h8000_0000);
        queue_item(OP_LOAD_MATRIX, 2, 2, 1, 0, 32'hffff_ffff);
        queue_item(OP_LOAD_MATRIX, 3, 3, 1, 0, 32'h0000_0001);
        // zero-size file dimension, then step after the failed start
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_FILE, 2, 0, 1, 0, 0);
        // region runs one past the end of a full-size dimension
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_MATRIX, 1, 1, 1, 0, 32'h8000_0000);
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_MATRIX, 1, 0, 1, 0, 32'h8000_0000);
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_MATRIX, 1, 5, 1, 0, 32'h8000_0000);
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_MATRIX, 1, 1, 0, 0, 32'h8000_0000);
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD_MATRIX, 1, 1, 1, 0, 32'h8000_0000);
        // leave a walk armed across the next register writes
        queue_item(OP_START, 0, 0, 0, 0, 0);
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        drain();

        // rank out of range in every way
        run_phase(0, 1, 0, 0, 20, 0, 0);
        run_phase(5, 2, 0, 0, 20, 0, 0);
        run_phase(7, 7, 0, 0, 20, 0, 0);
        run_phase(2, 3, 0, 0, 20, 0, 0);
        run_phase(4, 0, 0, 0, 20, 0, 0);

        run_phase(4, 4, 0, 0, 250, 0, 1);
        run_phase(4, 2, 252, 65535, 200, 0, 0);
        run_phase(1, 1, 255, 1000, 150, 0, 0);
        run_phase(2, 1, 17, 0, 150, 0, 0);
        run_phase(3, 3, 200, 40000, 200, 0, 0);
        run_phase(4, 4, 0, 0, 200, 1, 0);
        for (k = 0; k < 3; k++)
            run_phase(4, $urandom_range(4, 1), $urandom_range(252), $urandom_range(65535),
                      130, 0, 0);

        if (due_results.size() != 0)
            flag_mismatch("results never seen", 0, due_results.size());
        $display("tb: %0d items, %0d results checked, %0d walks run to the last point",
                 n_taken, n_checked, n_walks);
        $display("tb: %0d starts rejected, %0d steps outside a walk, %0d mismatches",
                 n_rejected, n_idle_steps, n_mismatch);
        if (n_mismatch == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
